// ===== sv/array_linked_list_engine_macros.svh =====
// Assertion macros shared by the checker of the list engine.
// Depends on nothing; included by files that assert.
`ifndef ARRAY_LINKED_LIST_ENGINE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ALLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("list engine check failed");

// Next-cycle implication, held off during reset.
`define ALLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

// ===== sv/alle_pkg.sv =====
// Shared types and codes of the linked list engine.
// Depends on nothing; imported by controller, datapath and top level.
package alle_pkg;

	localparam int CAPACITY = 64;

	localparam logic [2:0] CMD_INS_AFTER  = 3'd0;
	localparam logic [2:0] CMD_INS_BEFORE = 3'd1;
	localparam logic [2:0] CMD_DELETE     = 3'd2;
	localparam logic [2:0] CMD_LOOKUP     = 3'd3;
	localparam logic [2:0] CMD_LINEARIZE  = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_WRONG_INDEX = 3'd1;
	localparam logic [2:0] ST_EMPTY_NODE  = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

	localparam logic [31:0] POISON_VALUE = 32'h0000_DEAD;

	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LATCH     = 4'd1;
	localparam logic [3:0] OP_RD_POS    = 4'd2;
	localparam logic [3:0] OP_RD_HEAD   = 4'd3;
	localparam logic [3:0] OP_RD_ANCH   = 4'd4;
	localparam logic [3:0] OP_RD_FH     = 4'd5;
	localparam logic [3:0] OP_WR_SLOT   = 4'd6;
	localparam logic [3:0] OP_WR_LINK   = 4'd7;
	localparam logic [3:0] OP_DEL_LINK  = 4'd8;
	localparam logic [3:0] OP_DEL_FREE  = 4'd9;
	localparam logic [3:0] OP_LK_START  = 4'd10;
	localparam logic [3:0] OP_LK_STEP   = 4'd11;
	localparam logic [3:0] OP_LIN_START = 4'd12;
	localparam logic [3:0] OP_LIN_STEP  = 4'd13;
	localparam logic [3:0] OP_SWEEP     = 4'd14;

	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_POS  = 2'd1;
	localparam logic [1:0] SEL_WALK = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic       set_res;
		logic [2:0] res_code;
		logic [1:0] res_sel;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       pos_zero;
		logic       pos_oob;
		logic       full;
		logic       in_order;
		logic       pos_lt_fh;
		logic       rd_free;
		logic       walk_stop;
		logic       walk_hit;
		logic       lin_more;
		logic       sweep_last;
	} dp_status_t;

endpackage

// ===== sv/alle_dpath.sv =====
// Datapath of the linked list engine: node stores, scratch store, link registers.
// Depends on alle_pkg; driven by alle_ctrl through dp_cmd_t.
module alle_dpath import alle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  cmd,
	input  logic [5:0]  position,
	input  logic [31:0] value,
	input  dp_cmd_t     dcmd,
	output dp_status_t  dstat,
	output logic [2:0]  status,
	output logic [5:0]  physical_slot
);

	localparam int A = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int L = $clog2(CAPACITY + 1);
	localparam logic [L-1:0] LINK_NONE = L'(CAPACITY);

	logic [31:0]  val_mem  [CAPACITY];
	logic [L-1:0] next_mem [CAPACITY];
	logic [L-1:0] prev_mem [CAPACITY];
	logic         free_mem [CAPACITY];
	logic [31:0]  scr_mem  [CAPACITY];

	logic [2:0]   cmd_q;
	logic [5:0]   pos_q;
	logic [31:0]  val_q;
	logic [L-1:0] fh_q, anchor_q, nx_q, slot_q, pprev_q;
	logic         pfree_q, ord_q, first_q;
	logic [5:0]   c_q;
	logic [A-1:0] n_q, k_q;
	logic [2:0]   res_status_q;
	logic [5:0]   res_slot_q;

	logic [L-1:0] rnext_q, rprev_q;
	logic         rfree_q;
	logic [31:0]  rval_q, rscr_q;

	logic [A-1:0] rd_addr, pos_idx, lin_neff;
	logic [L-1:0] anchor_c;
	logic         lin_more_c;
	logic         nw_en, pw_en, vw_en, fw_en, sw_en;
	logic [A-1:0] nw_addr, pw_addr, vw_addr, fw_addr;
	logic [L-1:0] nw_data, pw_data;
	logic [31:0]  vw_data;
	logic         fw_data;

	assign pos_idx  = A'(pos_q);
	assign anchor_c = (cmd_q == CMD_INS_AFTER) ? (pfree_q ? rprev_q : L'(pos_q)) : pprev_q;
	assign lin_neff = n_q + A'(!first_q);
	assign lin_more_c = (rnext_q != '0) && (int'(rnext_q) < CAPACITY)
		&& (int'(lin_neff) < CAPACITY - 1);

	always_comb begin
		dstat.cmd        = cmd_q;
		dstat.pos_zero   = (pos_q == '0);
		dstat.pos_oob    = (int'(pos_q) >= CAPACITY);
		dstat.full       = (int'(fh_q) >= CAPACITY);
		dstat.in_order   = ord_q;
		dstat.pos_lt_fh  = (int'(pos_q) < int'(fh_q));
		dstat.rd_free    = rfree_q;
		dstat.walk_stop  = (rnext_q == '0) || (int'(rnext_q) >= CAPACITY);
		dstat.walk_hit   = ((7'(c_q) + 7'd1) == 7'(pos_q));
		dstat.lin_more   = lin_more_c;
		dstat.sweep_last = (k_q == A'(CAPACITY - 1));
	end

	// Address and write decode for each op.
	always_comb begin
		rd_addr = '0;
		nw_en = 1'b0; nw_addr = '0; nw_data = '0;
		pw_en = 1'b0; pw_addr = '0; pw_data = '0;
		vw_en = 1'b0; vw_addr = '0; vw_data = '0;
		fw_en = 1'b0; fw_addr = '0; fw_data = 1'b0;
		sw_en = 1'b0;
		unique case (dcmd.op)
			OP_RD_POS:  rd_addr = pos_idx;
			OP_RD_ANCH: rd_addr = anchor_c[A-1:0];
			OP_RD_FH:   rd_addr = fh_q[A-1:0];
			OP_LK_STEP: rd_addr = rnext_q[A-1:0];
			OP_LIN_STEP: begin
				rd_addr = rnext_q[A-1:0];
				sw_en   = !first_q;
			end
			OP_WR_SLOT: begin
				nw_en = 1'b1; nw_addr = fh_q[A-1:0]; nw_data = nx_q;
				pw_en = 1'b1; pw_addr = fh_q[A-1:0]; pw_data = anchor_q;
				vw_en = 1'b1; vw_addr = fh_q[A-1:0]; vw_data = val_q;
				fw_en = 1'b1; fw_addr = fh_q[A-1:0]; fw_data = 1'b0;
			end
			OP_WR_LINK: begin
				nw_en = 1'b1; nw_addr = anchor_q[A-1:0]; nw_data = slot_q;
				pw_en = (int'(nx_q) < CAPACITY); pw_addr = nx_q[A-1:0]; pw_data = slot_q;
			end
			OP_DEL_LINK: begin
				nw_en = (int'(rprev_q) < CAPACITY); nw_addr = rprev_q[A-1:0];
				nw_data = rnext_q;
				pw_en = (int'(rnext_q) < CAPACITY); pw_addr = rnext_q[A-1:0];
				pw_data = rprev_q;
			end
			OP_DEL_FREE: begin
				nw_en = 1'b1; nw_addr = pos_idx; nw_data = fh_q;
				pw_en = 1'b1; pw_addr = pos_idx; pw_data = LINK_NONE;
				vw_en = 1'b1; vw_addr = pos_idx; vw_data = POISON_VALUE;
				fw_en = 1'b1; fw_addr = pos_idx; fw_data = 1'b1;
			end
			OP_SWEEP: begin
				rd_addr = k_q;
				nw_en = 1'b1; nw_addr = k_q;
				pw_en = 1'b1; pw_addr = k_q;
				vw_en = 1'b1; vw_addr = k_q;
				fw_en = 1'b1; fw_addr = k_q;
				if (k_q == '0) begin
					nw_data = (n_q != '0) ? L'(1) : '0;
					pw_data = L'(n_q);
					vw_data = POISON_VALUE;
					fw_data = 1'b1;
				end else if (k_q > n_q) begin
					nw_data = L'(k_q) + L'(1);
					pw_data = LINK_NONE;
					vw_data = POISON_VALUE;
					fw_data = 1'b1;
				end else begin
					nw_data = (k_q == n_q) ? '0 : L'(k_q) + L'(1);
					pw_data = L'(k_q) - L'(1);
					vw_data = rscr_q;
					fw_data = 1'b0;
				end
			end
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nw_en) next_mem[nw_addr] <= nw_data;
		if (pw_en) prev_mem[pw_addr] <= pw_data;
		if (vw_en) val_mem[vw_addr] <= vw_data;
		if (fw_en) free_mem[fw_addr] <= fw_data;
		if (sw_en) scr_mem[n_q] <= rval_q;
		rnext_q <= next_mem[rd_addr];
		rprev_q <= prev_mem[rd_addr];
		rfree_q <= free_mem[rd_addr];
		rval_q  <= val_mem[rd_addr];
		rscr_q  <= scr_mem[rd_addr];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_LATCH: begin
				cmd_q <= cmd;
				pos_q <= position;
				val_q <= value;
			end
			OP_RD_HEAD: begin
				pfree_q <= rfree_q;
				pprev_q <= rprev_q;
			end
			OP_RD_ANCH:  anchor_q <= anchor_c;
			OP_RD_FH:    nx_q <= rnext_q;
			OP_WR_SLOT:  slot_q <= fh_q;
			OP_LK_START: c_q <= '0;
			OP_LK_STEP:  c_q <= c_q + 6'd1;
			default: ;
		endcase
		if (dcmd.set_res) begin
			res_status_q <= dcmd.res_code;
			case (dcmd.res_sel)
				SEL_POS:  res_slot_q <= pos_q;
				SEL_WALK: res_slot_q <= 6'(rnext_q);
				default:  res_slot_q <= '0;
			endcase
		end
		if (dcmd.load_out) begin
			status        <= res_status_q;
			physical_slot <= res_slot_q;
		end
	end

	// List state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q    <= L'(1);
			ord_q   <= 1'b1;
			n_q     <= '0;
			k_q     <= '0;
			first_q <= 1'b1;
		end else begin
			case (dcmd.op)
				OP_WR_SLOT: begin
					fh_q  <= rnext_q;
					ord_q <= ord_q && (int'(fh_q) == int'(anchor_q) + 1);
				end
				OP_DEL_FREE: begin
					fh_q  <= L'(pos_q);
					ord_q <= ord_q && (int'(pos_q) + 1 == int'(fh_q));
				end
				OP_LIN_START: begin
					n_q     <= '0;
					first_q <= 1'b1;
				end
				OP_LIN_STEP: begin
					n_q     <= lin_neff;
					first_q <= 1'b0;
				end
				OP_SWEEP: begin
					if (k_q == A'(CAPACITY - 1)) begin
						k_q   <= '0;
						fh_q  <= L'(n_q) + L'(1);
						ord_q <= 1'b1;
					end else begin
						k_q <= k_q + A'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/alle_ctrl.sv =====
// Controller of the linked list engine: sequences each command over the datapath.
// Depends on alle_pkg; drives alle_dpath through dp_cmd_t.
module alle_ctrl import alle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t dstat,
	output dp_cmd_t    dcmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_INS_CHK  = 4'd2;
	localparam logic [3:0] S_INS_ANCH = 4'd3;
	localparam logic [3:0] S_INS_FH   = 4'd4;
	localparam logic [3:0] S_INS_WS   = 4'd5;
	localparam logic [3:0] S_INS_WL   = 4'd6;
	localparam logic [3:0] S_DEL_CHK  = 4'd7;
	localparam logic [3:0] S_DEL_FR   = 4'd8;
	localparam logic [3:0] S_LK_STEP  = 4'd9;
	localparam logic [3:0] S_LIN_STEP = 4'd10;
	localparam logic [3:0] S_SWEEP    = 4'd11;
	localparam logic [3:0] S_DONE     = 4'd12;

	logic [3:0] state_q, state_d;
	logic       clear_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		dcmd = '{op: OP_NONE, set_res: 1'b0, res_code: ST_OK, res_sel: SEL_ZERO,
			load_out: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.op = OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				dcmd.set_res = 1'b1;
				case (dstat.cmd) inside
					CMD_INS_AFTER: begin
						if (dstat.pos_oob) dcmd.res_code = ST_WRONG_INDEX;
						else if (dstat.full) dcmd.res_code = ST_FULL;
						else begin
							dcmd.set_res = 1'b0;
							dcmd.op = OP_RD_POS;
							state_d = S_INS_CHK;
						end
					end
					CMD_INS_BEFORE, CMD_DELETE: begin
						if (dstat.pos_zero || dstat.pos_oob) dcmd.res_code = ST_WRONG_INDEX;
						else begin
							dcmd.set_res = 1'b0;
							dcmd.op = OP_RD_POS;
							state_d = (dstat.cmd == CMD_DELETE) ? S_DEL_CHK : S_INS_CHK;
						end
					end
					CMD_LOOKUP: begin
						if (dstat.pos_zero) dcmd.res_code = ST_WRONG_INDEX;
						else if (dstat.pos_oob) dcmd.res_code = ST_NOT_FOUND;
						else if (dstat.in_order) begin
							if (dstat.pos_lt_fh) dcmd.res_sel = SEL_POS;
							else dcmd.res_code = ST_NOT_FOUND;
						end else begin
							dcmd.set_res = 1'b0;
							dcmd.op = OP_LK_START;
							state_d = S_LK_STEP;
						end
					end
					CMD_LINEARIZE: begin
						dcmd.set_res = 1'b0;
						dcmd.op = OP_LIN_START;
						state_d = S_LIN_STEP;
					end
					default: dcmd.res_code = ST_WRONG_INDEX;
				endcase
			end
			S_INS_CHK: begin
				if (dstat.cmd == CMD_INS_BEFORE && dstat.rd_free) begin
					dcmd.set_res = 1'b1;
					dcmd.res_code = ST_WRONG_INDEX;
					state_d = S_DONE;
				end else if (dstat.full) begin
					dcmd.set_res = 1'b1;
					dcmd.res_code = ST_FULL;
					state_d = S_DONE;
				end else begin
					dcmd.op = OP_RD_HEAD;
					state_d = S_INS_ANCH;
				end
			end
			S_INS_ANCH: begin
				dcmd.op = OP_RD_ANCH;
				state_d = S_INS_FH;
			end
			S_INS_FH: begin
				dcmd.op = OP_RD_FH;
				state_d = S_INS_WS;
			end
			S_INS_WS: begin
				dcmd.op = OP_WR_SLOT;
				state_d = S_INS_WL;
			end
			S_INS_WL: begin
				dcmd.op = OP_WR_LINK;
				dcmd.set_res = 1'b1;
				state_d = S_DONE;
			end
			S_DEL_CHK: begin
				if (dstat.rd_free) begin
					dcmd.set_res = 1'b1;
					dcmd.res_code = ST_EMPTY_NODE;
					state_d = S_DONE;
				end else begin
					dcmd.op = OP_DEL_LINK;
					state_d = S_DEL_FR;
				end
			end
			S_DEL_FR: begin
				dcmd.op = OP_DEL_FREE;
				dcmd.set_res = 1'b1;
				state_d = S_DONE;
			end
			S_LK_STEP: begin
				dcmd.op = OP_LK_STEP;
				if (dstat.walk_stop) begin
					dcmd.set_res = 1'b1;
					dcmd.res_code = ST_NOT_FOUND;
					state_d = S_DONE;
				end else if (dstat.walk_hit) begin
					dcmd.set_res = 1'b1;
					dcmd.res_sel = SEL_WALK;
					state_d = S_DONE;
				end
			end
			S_LIN_STEP: begin
				dcmd.op = OP_LIN_STEP;
				if (!dstat.lin_more) state_d = S_SWEEP;
			end
			S_SWEEP: begin
				dcmd.op = OP_SWEEP;
				if (dstat.sweep_last) begin
					dcmd.set_res = !clear_q;
					state_d = clear_q ? S_IDLE : S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					dcmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			clear_q   <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SWEEP && dstat.sweep_last) clear_q <= 1'b0;
			if (dcmd.load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

endmodule

// ===== sv/array_linked_list_engine.sv =====
// Top level of the array-backed doubly linked list engine.
// Depends on alle_pkg, alle_ctrl and alle_dpath.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | in_valid, in_stall | cmd[2:0], position[5:0], value[31:0]
//   output  | out_valid,out_stall| status[2:0], physical_slot[5:0]
//
// One beat in gives one beat out. Insert passes through dispatch, a slot
// check, anchor and free-head reads, a slot write and a link write; delete
// through dispatch, a slot check with unlink, and a free; a walked lookup
// steps one hop per state; linearize walks the list, then sweeps every slot.
// Every store has one read port, so link hops are read one after another.
// After reset a clearing pass over all CAPACITY slots fills the stores; in_stall
// holds high meanwhile. The result register lets an item be accepted while
// the previous result still waits under out_stall.
module array_linked_list_engine import alle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [5:0]  position,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  physical_slot
);

	// Command and status between the sequencer and the stores.
	dp_cmd_t    dcmd;
	dp_status_t dstat;

	// Sequencer: one state per dependent store access.
	alle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dstat     (dstat),
		.dcmd      (dcmd)
	);

	// Stores, free chain, ordering flag and result register.
	alle_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.position      (position),
		.value         (value),
		.dcmd          (dcmd),
		.dstat         (dstat),
		.status        (status),
		.physical_slot (physical_slot)
	);

endmodule

// ===== sv/alle_checker.sv =====
// Port-level checks of the linked list engine, bound to the top level.
// Depends on alle_pkg and array_linked_list_engine_macros.svh.
`include "array_linked_list_engine_macros.svh"
module alle_checker import alle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [5:0] physical_slot
);

	// A result waiting under stall stays offered.
	`ALLE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// An accepted beat leaves the block busy in the next cycle.
	`ALLE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// A command that does not succeed reports slot zero.
	`ALLE_ASSERT_NOW(a_slot_only_ok, clk, arst_n, out_valid && status != ST_OK,
		physical_slot == 6'd0)
	// Status is one of the five codes.
	`ALLE_ASSERT_NOW(a_status_code, clk, arst_n, out_valid,
		status == ST_OK || status == ST_WRONG_INDEX || status == ST_EMPTY_NODE ||
		status == ST_FULL || status == ST_NOT_FOUND)

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.physical_slot (physical_slot)
);
